// ===== hw/rtl/rlss_pkg.sv =====
package rlss_pkg;

    localparam int MAX_LEDS    = 8;
    localparam int LED_IDX_W   = $clog2(MAX_LEDS);
    localparam int LED_CNT_W   = 4;
    localparam int KIND_W      = 2;
    localparam int COLOR_W     = 32;
    localparam int BIT_POS_W   = $clog2(COLOR_W);
    localparam int BIT_TICK_W  = 16;
    localparam int TICK_W      = 20;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = TICK_W;

    // Reset values of the timing registers
    localparam logic [BIT_TICK_W-1:0] ONE_HIGH_RST  = BIT_TICK_W'(14);
    localparam logic [BIT_TICK_W-1:0] ONE_LOW_RST   = BIT_TICK_W'(12);
    localparam logic [BIT_TICK_W-1:0] ZERO_HIGH_RST = BIT_TICK_W'(7);
    localparam logic [BIT_TICK_W-1:0] ZERO_LOW_RST  = BIT_TICK_W'(16);
    localparam logic [TICK_W-1:0]     RESET_RST     = TICK_W'(1200);
    localparam logic [LED_CNT_W-1:0]  LED_COUNT_RST = LED_CNT_W'(8);

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_START = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ONE_HIGH  = 3'd0,
        CFG_ONE_LOW   = 3'd1,
        CFG_ZERO_HIGH = 3'd2,
        CFG_ZERO_LOW  = 3'd3,
        CFG_RESET     = 3'd4,
        CFG_LED_COUNT = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_PRE   = 3'd1,
        PH_HIGH  = 3'd2,
        PH_LOW   = 3'd3,
        PH_LATCH = 3'd4
    } phase_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
    } result_t;

    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage

// ===== hw/rtl/rlss_if.sv =====
interface rlss_in_if;
    logic                          valid;
    logic                          ready;
    logic [rlss_pkg::KIND_W-1:0]   kind;
    logic [rlss_pkg::LED_IDX_W-1:0] pixel_index;
    logic [rlss_pkg::COLOR_W-1:0]  pixel_color;

    modport source (output valid, kind, pixel_index, pixel_color, input ready);
    modport sink   (input valid, kind, pixel_index, pixel_color, output ready);
endinterface

interface rlss_out_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic frame_done;

    modport source (output valid, line_level, busy_res, frame_done, input ready);
    modport sink   (input valid, line_level, busy_res, frame_done, output ready);
endinterface

// ===== hw/rtl/rgbw_led_strip_serializer.sv =====
// Channel   Dir   Payload                                  Transfer
// in_ch     in    kind, pixel_index, pixel_color           valid & ready
// out_ch    out   line_level, busy_res, frame_done         valid & ready
// cfg       in    cfg_we, cfg_index, cfg_data              cfg_we high
//
// One item per clock while input ready is high; each yields one result.
// The pixel store is a synchronous memory (registered read); its read address
// follows the next state, so the word needed at a start or a word boundary is
// already registered. A two-entry result queue decouples the sides: input
// ready drops only while both entries are held. Reset is asynchronous; the
// store reads as zero until written, tracked by one valid bit per entry.
module rgbw_led_strip_serializer (
    input  logic                                clk,
    input  logic                                rst_n,
    rlss_in_if.sink                             in_ch,
    rlss_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [rlss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rlss_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rlss_pkg::*;

    // Configuration registers
    logic [BIT_TICK_W-1:0] one_high_reg, one_low_reg, zero_high_reg, zero_low_reg;
    logic [TICK_W-1:0]     reset_ticks_reg;
    logic [LED_CNT_W-1:0]  led_count_reg;

    // Sequencer state
    phase_t                phase_reg, phase_next;
    logic [TICK_W-1:0]     tick_left_reg, tick_left_next;
    logic [BIT_POS_W-1:0]  bit_pos_reg, bit_pos_next;
    logic [LED_IDX_W-1:0]  led_pos_reg, led_pos_next;
    logic [COLOR_W-1:0]    shift_reg, shift_next;

    // Pixel store
    logic [COLOR_W-1:0]    pix_mem [MAX_LEDS];
    logic [MAX_LEDS-1:0]   pix_valid_reg;
    logic [COLOR_W-1:0]    rd_data_reg;
    logic [LED_IDX_W-1:0]  rd_addr;
    logic                  mem_we;

    // Result queue
    result_t               slot0_reg, slot0_next, slot1_reg, slot1_next;
    logic [1:0]            count_reg, count_next;
    result_t               res;

    logic                  in_fire, out_fire;
    logic [LED_CNT_W-1:0]  frame_leds;
    logic [TICK_W-1:0]     tl_dec;
    logic                  cur_bit, new_bit;
    logic [BIT_POS_W-1:0]  bit_pos_dec;

    assign in_ch.ready = (count_reg != 2'd2);
    assign in_fire     = in_ch.valid & in_ch.ready;
    assign out_ch.valid = (count_reg != 2'd0);
    assign out_fire    = out_ch.valid & out_ch.ready;
    assign out_ch.line_level = slot0_reg.line_level;
    assign out_ch.busy_res   = slot0_reg.busy_res;
    assign out_ch.frame_done = slot0_reg.frame_done;

    // Words per frame, clamped to 1..MAX_LEDS
    always_comb
    begin
        if (led_count_reg == '0)
            frame_leds = LED_CNT_W'(1);
        else if (led_count_reg > LED_CNT_W'(MAX_LEDS))
            frame_leds = LED_CNT_W'(MAX_LEDS);
        else
            frame_leds = led_count_reg;
    end

    assign tl_dec      = tick_left_reg - TICK_W'(1);
    assign bit_pos_dec = bit_pos_reg - BIT_POS_W'(1);
    assign cur_bit     = shift_reg[bit_pos_reg];
    assign new_bit     = shift_reg[bit_pos_dec];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_high_reg    <= ONE_HIGH_RST;
            one_low_reg     <= ONE_LOW_RST;
            zero_high_reg   <= ZERO_HIGH_RST;
            zero_low_reg    <= ZERO_LOW_RST;
            reset_ticks_reg <= RESET_RST;
            led_count_reg   <= LED_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ONE_HIGH:  one_high_reg    <= cfg_data[BIT_TICK_W-1:0];
                CFG_ONE_LOW:   one_low_reg     <= cfg_data[BIT_TICK_W-1:0];
                CFG_ZERO_HIGH: zero_high_reg   <= cfg_data[BIT_TICK_W-1:0];
                CFG_ZERO_LOW:  zero_low_reg    <= cfg_data[BIT_TICK_W-1:0];
                CFG_RESET:     reset_ticks_reg <= cfg_data;
                CFG_LED_COUNT: led_count_reg   <= cfg_data[LED_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state and the result of the accepted item
    always_comb
    begin
        phase_next     = phase_reg;
        tick_left_next = tick_left_reg;
        bit_pos_next   = bit_pos_reg;
        led_pos_next   = led_pos_reg;
        shift_next     = shift_reg;
        mem_we         = 1'b0;
        res.line_level = (phase_reg == PH_HIGH);
        res.busy_res   = (phase_reg != PH_IDLE);
        res.frame_done = 1'b0;

        if (in_fire)
        begin
            if (kind_t'(in_ch.kind) == KIND_TICK)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    tick_left_next = tl_dec;
                    if (tl_dec == '0)
                    begin
                        unique case (phase_reg)
                            PH_PRE:
                            begin
                                phase_next     = PH_HIGH;
                                tick_left_next = at_least_one(TICK_W'(cur_bit ?
                                                 one_high_reg : zero_high_reg));
                            end
                            PH_HIGH:
                            begin
                                phase_next     = PH_LOW;
                                tick_left_next = at_least_one(TICK_W'(cur_bit ?
                                                 one_low_reg : zero_low_reg));
                            end
                            PH_LOW:
                            begin
                                if (bit_pos_reg != '0)
                                begin
                                    // Advance to the next bit of this word
                                    bit_pos_next   = bit_pos_dec;
                                    phase_next     = PH_HIGH;
                                    tick_left_next = at_least_one(TICK_W'(new_bit ?
                                                     one_high_reg : zero_high_reg));
                                end
                                else if ((LED_CNT_W'(led_pos_reg) + LED_CNT_W'(1))
                                         >= frame_leds)
                                begin
                                    phase_next     = PH_LATCH;
                                    tick_left_next = at_least_one(reset_ticks_reg);
                                    bit_pos_next   = '1;
                                end
                                else
                                begin
                                    // Next word was prefetched from the store
                                    led_pos_next   = led_pos_reg + LED_IDX_W'(1);
                                    shift_next     = rd_data_reg;
                                    bit_pos_next   = '1;
                                    phase_next     = PH_HIGH;
                                    tick_left_next = at_least_one(TICK_W'(
                                                     rd_data_reg[COLOR_W-1] ?
                                                     one_high_reg : zero_high_reg));
                                end
                            end
                            PH_LATCH:
                            begin
                                phase_next     = PH_IDLE;
                                tick_left_next = '0;
                                led_pos_next   = '0;
                                bit_pos_next   = '1;
                                res.frame_done = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            else
            begin
                if (phase_reg == PH_IDLE)
                begin
                    if (kind_t'(in_ch.kind) == KIND_WRITE)
                        mem_we = 1'b1;
                    else if (kind_t'(in_ch.kind) == KIND_START)
                    begin
                        phase_next     = PH_PRE;
                        tick_left_next = at_least_one(reset_ticks_reg);
                        led_pos_next   = '0;
                        bit_pos_next   = '1;
                        shift_next     = rd_data_reg;
                    end
                end
                res.line_level = (phase_next == PH_HIGH);
                res.busy_res   = (phase_next != PH_IDLE);
            end
        end
    end

    // Prefetch: word 0 while idle, otherwise the word after the current one
    assign rd_addr = (phase_next == PH_IDLE) ? '0 : (led_pos_next + LED_IDX_W'(1));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            pix_mem[in_ch.pixel_index] <= in_ch.pixel_color;
        // Forward a same-cycle write; unwritten entries read as zero
        if (mem_we && (in_ch.pixel_index == rd_addr))
            rd_data_reg <= in_ch.pixel_color;
        else if (pix_valid_reg[rd_addr])
            rd_data_reg <= pix_mem[rd_addr];
        else
            rd_data_reg <= '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_valid_reg <= '0;
        else if (mem_we)
            pix_valid_reg[in_ch.pixel_index] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_left_reg <= '0;
            bit_pos_reg   <= '1;
            led_pos_reg   <= '0;
            shift_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            tick_left_reg <= tick_left_next;
            bit_pos_reg   <= bit_pos_next;
            led_pos_reg   <= led_pos_next;
            shift_reg     <= shift_next;
        end
    end

    // Result queue: push on input transfer, pop on output transfer
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        unique case (count_reg)
            2'd0:
            begin
                if (in_fire)
                begin
                    slot0_next = res;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (in_fire && out_fire)
                    slot0_next = res;
                else if (in_fire)
                begin
                    slot1_next = res;
                    count_next = 2'd2;
                end
                else if (out_fire)
                    count_next = 2'd0;
            end
            2'd2:
            begin
                if (out_fire)
                begin
                    slot0_next = slot1_reg;
                    count_next = 2'd1;
                end
            end
            default: count_next = 2'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

endmodule

// ===== hw/rtl/rlss_checker.sv =====
module rlss_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic line_level,
    input logic busy_res,
    input logic frame_done
);
    // The line only goes high inside a frame
    a_level_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_level |-> busy_res)
        else $error("line high outside a frame");

    // Frame end is reported on a busy tick
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> busy_res && !line_level)
        else $error("frame done without busy low line");

    // An empty result queue never stalls the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty queue");

    // An input transfer always leaves a result waiting
    a_in_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("input transfer without a result");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({line_level, busy_res, frame_done}))
        else $error("stalled result changed");
endmodule

bind rgbw_led_strip_serializer rlss_checker u_rlss_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .line_level (out_ch.line_level),
    .busy_res   (out_ch.busy_res),
    .frame_done (out_ch.frame_done)
);

// ===== tb/strip_checker.sv =====
module strip_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    rlss_in_if                                  in_ch,
    rlss_out_if                                 out_ch,
    input  logic                                cfg_we,
    input  logic [rlss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rlss_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  mismatches,
    output int                                  leftover
);
    timeunit 1ns;
    timeprecision 1ps;
    import rlss_pkg::*;

    // Shadow copy of the timing registers
    logic [BIT_TICK_W-1:0] hi_one, lo_one, hi_zero, lo_zero;
    logic [TICK_W-1:0]     latch_ticks;
    logic [LED_CNT_W-1:0]  strip_leds;

    // Shadow copy of the waveform state
    logic [COLOR_W-1:0]    pixels [MAX_LEDS];
    phase_t                strip_phase;
    logic [TICK_W-1:0]     ticks_left;
    logic [BIT_POS_W-1:0]  bit_pos;
    logic [LED_IDX_W-1:0]  led_pos;
    logic [COLOR_W-1:0]    out_word;

    result_t               levels_due [$];

    function automatic logic [TICK_W-1:0] floor_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

    task automatic start_bit_high();
        strip_phase = PH_HIGH;
        ticks_left  = floor_one(out_word[bit_pos] ? {4'b0, hi_one} : {4'b0, hi_zero});
    endtask

    task automatic predict_level(input kind_t item_kind, input logic [LED_IDX_W-1:0] idx,
                                 input logic [COLOR_W-1:0] color, output result_t r);
        int leds_eff;
        leds_eff = (strip_leds == '0) ? 1 : (strip_leds > MAX_LEDS) ? MAX_LEDS : strip_leds;
        r.frame_done = 1'b0;
        if (item_kind == KIND_TICK)
        begin
            r.busy_res   = (strip_phase != PH_IDLE);
            r.line_level = (strip_phase == PH_HIGH);
            if (strip_phase != PH_IDLE)
            begin
                ticks_left = ticks_left - 1'b1;
                if (ticks_left == '0)
                begin
                    case (strip_phase)
                        PH_PRE:  start_bit_high();
                        PH_HIGH:
                        begin
                            strip_phase = PH_LOW;
                            ticks_left  = floor_one(out_word[bit_pos] ? {4'b0, lo_one}
                                                                      : {4'b0, lo_zero});
                        end
                        PH_LOW:
                        begin
                            if (bit_pos != '0)
                            begin
                                bit_pos = bit_pos - 1'b1;
                                start_bit_high();
                            end
                            else if (int'(led_pos) + 1 >= leds_eff)
                            begin
                                strip_phase = PH_LATCH;
                                ticks_left  = floor_one(latch_ticks);
                                bit_pos     = '1;
                            end
                            else
                            begin
                                led_pos  = led_pos + 1'b1;
                                out_word = pixels[led_pos];
                                bit_pos  = '1;
                                start_bit_high();
                            end
                        end
                        default:
                        begin
                            strip_phase  = PH_IDLE;
                            ticks_left   = '0;
                            led_pos      = '0;
                            bit_pos      = '1;
                            r.frame_done = 1'b1;
                        end
                    endcase
                end
            end
        end
        else
        begin
            if (strip_phase == PH_IDLE)
            begin
                if (item_kind == KIND_WRITE)
                begin
                    pixels[idx] = color;
                end
                else if (item_kind == KIND_START)
                begin
                    strip_phase = PH_PRE;
                    ticks_left  = floor_one(latch_ticks);
                    led_pos     = '0;
                    bit_pos     = '1;
                    out_word    = pixels[0];
                end
            end
            r.line_level = (strip_phase == PH_HIGH);
            r.busy_res   = (strip_phase != PH_IDLE);
        end
    endtask

    task automatic compare_bit(input string field, input logic want, input logic got);
        if (got !== want)
        begin
            mismatches++;
            $display("%t: %s mismatch, expected %0b actual %0b", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            hi_one      = ONE_HIGH_RST;
            lo_one      = ONE_LOW_RST;
            hi_zero     = ZERO_HIGH_RST;
            lo_zero     = ZERO_LOW_RST;
            latch_ticks = RESET_RST;
            strip_leds  = LED_COUNT_RST;
            foreach (pixels[i])
                pixels[i] = '0;
            strip_phase = PH_IDLE;
            ticks_left  = '0;
            bit_pos     = '1;
            led_pos     = '0;
            out_word    = '0;
            levels_due.delete();
            mismatches  = 0;
            leftover    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ONE_HIGH:  hi_one      = cfg_data[BIT_TICK_W-1:0];
                    CFG_ONE_LOW:   lo_one      = cfg_data[BIT_TICK_W-1:0];
                    CFG_ZERO_HIGH: hi_zero     = cfg_data[BIT_TICK_W-1:0];
                    CFG_ZERO_LOW:  lo_zero     = cfg_data[BIT_TICK_W-1:0];
                    CFG_RESET:     latch_ticks = cfg_data[TICK_W-1:0];
                    CFG_LED_COUNT: strip_leds  = cfg_data[LED_CNT_W-1:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got = {out_ch.line_level, out_ch.busy_res, out_ch.frame_done};
                if (levels_due.size() == 0)
                begin
                    mismatches++;
                    $display("%t: result with none expected, expected none actual %b",
                             $time, got);
                end
                else
                begin
                    want = levels_due.pop_front();
                    compare_bit("line_level", want.line_level, got.line_level);
                    compare_bit("busy_res", want.busy_res, got.busy_res);
                    compare_bit("frame_done", want.frame_done, got.frame_done);
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                predict_level(kind_t'(in_ch.kind), in_ch.pixel_index, in_ch.pixel_color, want);
                levels_due.push_back(want);
            end
            leftover = levels_due.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rlss_pkg::*;

    // Cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT    = 2000;
    // Length of the receiver hold-off that backs up the block
    localparam int LONG_HOLD      = 64;
    // Safety cap on items sent while waiting for one frame to end
    localparam int FRAME_TICK_CAP = 20000;
    localparam int RANDOM_ITEMS   = 250;
    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rlss_in_if  in_ch ();
    rlss_out_if out_ch ();

    int   mismatches;
    int   leftover;
    int   sent;             // input transfers so far
    int   received;         // output transfers so far
    int   frames_done;      // results seen with frame_done set
    int   quiet_cycles;
    logic last_busy = 1'b0; // frame state as of the newest result
    bit   sender_idles;
    bit   receiver_idles;

    always #2 clk = ~clk;

    rgbw_led_strip_serializer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    strip_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .leftover   (leftover)
    );

    // Offer one item; optionally drop valid for a random gap first, then hold
    // it until the transfer. Valid stays high when the next item follows with
    // no gap, so it is never lowered and raised in the same step.
    task automatic send(input kind_t item_kind, input logic [LED_IDX_W-1:0] idx,
                        input logic [COLOR_W-1:0] color);
        int gap;
        gap = sender_idles ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= item_kind;
        in_ch.pixel_index <= idx;
        in_ch.pixel_color <= color;
        do @(posedge clk); while (!in_ch.ready);
        sent++;
    endtask

    // Any kind at all, with random fields: writes and starts that land in a
    // frame are dropped by the block, the unused kind is always dropped.
    task automatic send_noise();
        send(kind_t'(KIND_W'($urandom_range(0, 3))), LED_IDX_W'($urandom), $urandom);
    endtask

    task automatic send_tick();
        send(KIND_TICK, LED_IDX_W'($urandom), $urandom);
    endtask

    // Drop valid and hold off until every result has come back.
    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (received != sent);
    endtask

    // One register write; the caller drops the write enable after a batch.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Write all six registers; bits above each register's width carry junk,
    // which the block has to discard.
    task automatic program_timing(input logic [BIT_TICK_W-1:0] one_hi, one_lo,
                                  input logic [BIT_TICK_W-1:0] zero_hi, zero_lo,
                                  input logic [TICK_W-1:0] latch,
                                  input logic [LED_CNT_W-1:0] leds);
        cfg_write(CFG_ONE_HIGH,  {4'($urandom), one_hi});
        cfg_write(CFG_ONE_LOW,   {4'($urandom), one_lo});
        cfg_write(CFG_ZERO_HIGH, {4'($urandom), zero_hi});
        cfg_write(CFG_ZERO_LOW,  {4'($urandom), zero_lo});
        cfg_write(CFG_RESET,     latch);
        cfg_write(CFG_LED_COUNT, {16'($urandom), leds});
        cfg_we <= 1'b0;
    endtask

    // Keep ticking (with some noise mixed in) until the running frame ends.
    task automatic run_frame(input int noise_pct);
        int target;
        int guard;
        target = frames_done + 1;
        guard  = 0;
        while (frames_done < target && guard < FRAME_TICK_CAP)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_noise();
            else
                send_tick();
            guard++;
        end
    endtask

    // Leave the block drained and out of any frame that noise may have begun.
    task automatic finish_frame();
        wait_drain();
        if (last_busy)
        begin
            run_frame(0);
            wait_drain();
        end
    endtask

    // A well-formed frame with random content: fill some pixels, start,
    // tick it through. Now and then a register changes in the middle of it.
    task automatic random_frame();
        int writes;
        finish_frame();
        sender_idles   = ($urandom_range(0, 4) != 0);
        receiver_idles = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 2) == 0)
            program_timing(BIT_TICK_W'($urandom_range(0, 2)),
                           BIT_TICK_W'($urandom_range(0, 2)),
                           BIT_TICK_W'($urandom_range(0, 2)),
                           BIT_TICK_W'($urandom_range(0, 2)),
                           TICK_W'($urandom_range(0, 4)),
                           LED_CNT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                                  : $urandom_range(0, 1)));
        writes = $urandom_range(0, 8);
        repeat (writes)
        begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            send(KIND_WRITE, LED_IDX_W'($urandom), $urandom);
        end
        send(KIND_START, LED_IDX_W'($urandom), $urandom);
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 40)) send_tick();
            wait_drain();
            cfg_write(CFG_IDX_W'($urandom_range(0, 7)), CFG_DATA_W'($urandom_range(0, 3)));
            cfg_we <= 1'b0;
        end
        run_frame(10);
    endtask

    // Receiver: draw a stall per result, and once in a while hold off long
    // enough that the block's result queue fills and it drops input ready.
    initial
    begin : receiver
        int stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (received % 500 == 250)
                stall = LONG_HOLD;
            else
                stall = receiver_idles ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            received++;
            // The tick that ends the latch still reads busy; the frame is over.
            last_busy = out_ch.busy_res && !out_ch.frame_done;
            if (out_ch.frame_done)
                frames_done++;
        end
    end

    // Watchdog: any cycle with a transfer on either channel resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int base;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_ONE_HIGH;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.kind        <= KIND_TICK;
        in_ch.pixel_index <= '0;
        in_ch.pixel_color <= '0;
        sender_idles       = 1'b1;
        receiver_idles     = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle tick and the unused kind right after reset, then fill both
        // ends of the store and run a short one-pixel frame.
        send(KIND_TICK, '0, '0);
        send(KIND_NONE, '1, '1);
        finish_frame();
        program_timing(16'd2, 16'd1, 16'd1, 16'd2, 20'd2, 4'd1);
        send(KIND_WRITE, 3'd0, 32'hFFFF_FFFF);
        send(KIND_WRITE, 3'd3, 32'h8000_0001);
        send(KIND_WRITE, 3'd7, 32'h5A5A_A5A5);
        send(KIND_START, '0, '0);
        // Drop a start, a write and the unused kind inside the frame.
        send(KIND_START, '0, '0);
        send(KIND_WRITE, 3'd0, 32'h0000_0000);
        send(KIND_NONE, '0, '0);
        run_frame(0);

        // Every register at zero: each counts as one, one pixel per frame.
        finish_frame();
        program_timing('0, '0, '0, '0, '0, '0);
        send(KIND_WRITE, 3'd0, 32'h8000_0001);
        send(KIND_START, '0, '0);
        run_frame(0);

        // A pixel count above the store size sends the whole store; zero
        // bits are the short ones since most of the store is unwritten.
        finish_frame();
        program_timing(16'd2, 16'd1, 16'd1, 16'd1, 20'd1, 4'd15);
        send(KIND_START, '0, '0);
        run_frame(0);

        // Long bit times, with no idling on either side: a single one bit
        // on the long one timing, then a single zero bit on the long zero timing.
        finish_frame();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        program_timing(16'd16, 16'd12, 16'd1, 16'd1, 20'd1, 4'd1);
        send(KIND_WRITE, 3'd0, 32'h0000_8000);
        send(KIND_START, '0, '0);
        run_frame(0);
        finish_frame();
        program_timing(16'd1, 16'd1, 16'd16, 16'd12, 20'd1, 4'd1);
        send(KIND_WRITE, 3'd0, 32'hFFFF_7FFF);
        send(KIND_START, '0, '0);
        run_frame(0);

        // Change the latch length inside a frame: the largest value lands in
        // the register but is replaced before the latch loads it. Write the
        // spare indexes on the way, which must change nothing.
        finish_frame();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        program_timing(16'd1, 16'd1, 16'd1, 16'd1, 20'd3, 4'd1);
        send(KIND_START, '0, '0);
        repeat (6) send_tick();
        wait_drain();
        cfg_write(CFG_RESET, 20'hF_FFFF);
        cfg_write(CFG_SPARE_LO, '0);
        cfg_we <= 1'b0;
        repeat (4) send_tick();
        wait_drain();
        cfg_write(CFG_RESET, 20'd2);
        cfg_write(CFG_SPARE_HI, '1);
        cfg_we <= 1'b0;
        run_frame(5);

        // Random frames, most of them short.
        base = sent;
        while (sent - base < RANDOM_ITEMS)
            random_frame();

        wait_drain();
        repeat (8) @(posedge clk);
        #1;
        if (mismatches == 0 && leftover == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rlss_pkg.sv
hw/rtl/rlss_if.sv
hw/rtl/rgbw_led_strip_serializer.sv
hw/rtl/rlss_checker.sv
tb/strip_checker.sv
tb/testbench.sv
